// ----- rtl/tccw_pkg.sv -----
// Package with the geometry, codes, state type and control structs of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    // Common width for comparing the 11-bit port fields against the cell count.
    localparam int WIDE_W     = (ADDR_W > 11) ? ADDR_W : 11;

    localparam logic [15:0] BLANK_CELL     = 16'h0720;
    localparam logic [7:0]  ATTR_FORCE     = 8'h07;
    localparam logic [7:0]  CODE_BACKSPACE = 8'h08;
    localparam logic [7:0]  CODE_NEWLINE   = 8'h0A;
    localparam logic [7:0]  CODE_RETURN    = 8'h0D;
    localparam logic [7:0]  CODE_SPACE     = 8'h20;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic clear_step;
        logic scroll_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scroll_needed;
        logic clear_last;
        logic sweep_last;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/text_console_char_writer.sv -----
// Top level of the text console writer: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Text-mode console with a ROWS by COLUMNS screen of 16-bit cells (attribute high byte,
// character low byte) and a cursor that starts at cell 0. Each beat on the slave side is a put
// (tuser 0: write a character, or act on backspace, newline or carriage return) or a read
// (tuser 1: return one cell); every beat yields exactly one beat on the master side with the
// cursor after the item, the read cell (0 for a put or an index past the screen) and a scroll
// flag. A put or read passes through the accept, execute and emit steps and holds the block
// throughout; its result beat is registered through the EXEC and DONE states into the output
// register, and DONE waits while an earlier result is stalled. A scroll copies the screen up one
// row through the screen memory, one cell per cycle. After reset the block first blanks the
// memory to 0x0720, one cell a cycle, before the first beat is accepted. A finished result
// waits in an output register and does not stop the next beat from being accepted.
module text_console_char_writer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata fields from bit 0: char_code[7:0], attribute[15:8], cell_index[26:16], zeros.
    input  wire logic [31:0] s_tdata,
    // s_tuser fields from bit 0: command[0].
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata fields from bit 0: cursor_position[10:0], cell_data[26:11], scrolled[27], zeros.
    output logic [31:0]      m_tdata
);

    tccw_pkg::ctrl_cmd_t  cmd;
    tccw_pkg::dp_status_t status;

    tccw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tccw_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/tccw_ctrl.sv -----
// Controller state machine of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

module tccw_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire tccw_pkg::dp_status_t status,
    output tccw_pkg::ctrl_cmd_t      cmd
);

    tccw_pkg::state_t state_reg;
    tccw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tccw_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tccw_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = tccw_pkg::ST_EXEC;
                end
            end
            tccw_pkg::ST_EXEC:
            begin
                if (status.scroll_needed)
                begin
                    state_next = tccw_pkg::ST_SCROLL;
                end
                else
                begin
                    state_next = tccw_pkg::ST_DONE;
                end
            end
            tccw_pkg::ST_SCROLL:
            begin
                if (status.sweep_last)
                begin
                    state_next = tccw_pkg::ST_DONE;
                end
            end
            tccw_pkg::ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tccw_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            tccw_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            tccw_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            tccw_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            tccw_pkg::ST_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
            end
            tccw_pkg::ST_DONE:
            begin
                cmd.emit = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tccw_datapath.sv -----
// Datapath of the text console writer: screen memory, cursor, sweep counter and result register.
`timescale 1ns / 1ps
`default_nettype none

module tccw_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tccw_pkg::ctrl_cmd_t cmd,
    output tccw_pkg::dp_status_t     status,
    input  wire logic [31:0]         s_tdata,
    input  wire logic [0:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata
);

    // Screen memory, one write and one registered read per cycle.
    logic [15:0] mem [tccw_pkg::CELL_COUNT];
    logic                        mem_we;
    logic [tccw_pkg::ADDR_W-1:0] mem_wa;
    logic [15:0]                 mem_wd;
    logic                        mem_re;
    logic [tccw_pkg::ADDR_W-1:0] mem_ra;
    logic [15:0]                 rdata_reg;

    // Latched item.
    logic                        cmd_reg;
    logic [7:0]                  ch_reg;
    logic [7:0]                  attr_reg;
    logic                        idx_ok_reg;
    logic [tccw_pkg::ADDR_W-1:0] idx_addr_reg;
    logic                        scrolled_reg;

    // Cursor kept as linear position plus row and column.
    logic [tccw_pkg::ADDR_W-1:0] cur_reg;
    logic [tccw_pkg::ADDR_W-1:0] cur_next;
    logic [tccw_pkg::COL_W-1:0]  col_reg;
    logic [tccw_pkg::COL_W-1:0]  col_next;
    logic [tccw_pkg::ROW_W-1:0]  row_reg;
    logic [tccw_pkg::ROW_W-1:0]  row_next;
    logic [tccw_pkg::CNT_W-1:0]  cnt_reg;
    logic [tccw_pkg::CNT_W-1:0]  cnt_next;

    logic                        out_valid_reg;
    logic [10:0]                 out_cursor_reg;
    logic [15:0]                 out_cell_reg;
    logic                        out_scrolled_reg;

    logic [tccw_pkg::WIDE_W-1:0] idx_wide;
    logic [tccw_pkg::WIDE_W-1:0] cur_wide;
    logic [tccw_pkg::CNT_W-1:0]  src_cnt;
    logic [tccw_pkg::CNT_W-1:0]  dst_cnt;
    logic [tccw_pkg::ADDR_W-1:0] cur_line;
    logic                        at_last_col;
    logic                        at_last_row;
    logic                        is_bs;
    logic                        is_nl;
    logic                        is_cr;
    logic                        scroll_needed;

    assign idx_wide    = tccw_pkg::WIDE_W'(s_tdata[26:16]);
    assign cur_wide    = tccw_pkg::WIDE_W'(cur_reg);
    assign src_cnt     = cnt_reg + tccw_pkg::CNT_W'(tccw_pkg::COLUMNS);
    assign dst_cnt     = cnt_reg - tccw_pkg::CNT_W'(1);
    assign cur_line    = cur_reg - tccw_pkg::ADDR_W'(col_reg);
    assign at_last_col = (col_reg == tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1));
    assign at_last_row = (row_reg == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1));
    assign is_bs       = (ch_reg == tccw_pkg::CODE_BACKSPACE);
    assign is_nl       = (ch_reg == tccw_pkg::CODE_NEWLINE);
    assign is_cr       = (ch_reg == tccw_pkg::CODE_RETURN);

    // A newline on the last row or a write at the last cell scrolls the screen.
    assign scroll_needed = (cmd_reg == tccw_pkg::CMD_PUT) && at_last_row &&
                           (is_nl || (!is_bs && !is_cr && at_last_col));

    assign status.scroll_needed = scroll_needed;
    assign status.clear_last    = (cnt_reg == tccw_pkg::CNT_W'(tccw_pkg::CELL_COUNT - 1));
    assign status.sweep_last    = (cnt_reg == tccw_pkg::CNT_W'(tccw_pkg::CELL_COUNT));
    assign status.out_busy      = out_valid_reg && !m_tready;

    // Memory port selection.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cur_reg;
        mem_wd = {attr_reg, ch_reg};
        mem_re = 1'b0;
        mem_ra = idx_addr_reg;
        if (cmd.clear_step)
        begin
            mem_we = 1'b1;
            mem_wa = cnt_reg[tccw_pkg::ADDR_W-1:0];
            mem_wd = tccw_pkg::BLANK_CELL;
        end
        else if (cmd.scroll_step)
        begin
            // Read one row ahead; the word read last cycle lands one cell behind the counter.
            mem_re = (cnt_reg < tccw_pkg::CNT_W'(tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS));
            mem_ra = src_cnt[tccw_pkg::ADDR_W-1:0];
            mem_we = (cnt_reg != '0);
            mem_wa = dst_cnt[tccw_pkg::ADDR_W-1:0];
            if (cnt_reg <= tccw_pkg::CNT_W'(tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS))
            begin
                mem_wd = rdata_reg;
            end
            else
            begin
                mem_wd = tccw_pkg::BLANK_CELL;
            end
        end
        else if (cmd.exec)
        begin
            if (cmd_reg == tccw_pkg::CMD_READ)
            begin
                mem_re = idx_ok_reg;
            end
            else if (is_bs)
            begin
                mem_we = (cur_reg != '0);
                mem_wa = cur_reg - tccw_pkg::ADDR_W'(1);
                mem_wd = {attr_reg, tccw_pkg::CODE_SPACE};
            end
            else if (!is_nl && !is_cr)
            begin
                mem_we = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    // Cursor and sweep counter update.
    always_comb
    begin
        cur_next = cur_reg;
        col_next = col_reg;
        row_next = row_reg;
        cnt_next = cnt_reg;
        if (cmd.clear_step || cmd.scroll_step)
        begin
            cnt_next = cnt_reg + tccw_pkg::CNT_W'(1);
        end
        if (cmd.exec)
        begin
            cnt_next = '0;
            if (cmd_reg == tccw_pkg::CMD_PUT)
            begin
                if (is_bs)
                begin
                    if (cur_reg != '0)
                    begin
                        cur_next = cur_reg - tccw_pkg::ADDR_W'(1);
                        if (col_reg == '0)
                        begin
                            col_next = tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1);
                            row_next = row_reg - tccw_pkg::ROW_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg - tccw_pkg::COL_W'(1);
                        end
                    end
                end
                else if (is_nl)
                begin
                    col_next = '0;
                    if (at_last_row)
                    begin
                        cur_next = cur_line;
                    end
                    else
                    begin
                        cur_next = cur_line + tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
                        row_next = row_reg + tccw_pkg::ROW_W'(1);
                    end
                end
                else if (is_cr)
                begin
                    cur_next = cur_line;
                    col_next = '0;
                end
                else if (at_last_col)
                begin
                    col_next = '0;
                    if (at_last_row)
                    begin
                        cur_next = tccw_pkg::ADDR_W'(tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS);
                    end
                    else
                    begin
                        cur_next = cur_reg + tccw_pkg::ADDR_W'(1);
                        row_next = row_reg + tccw_pkg::ROW_W'(1);
                    end
                end
                else
                begin
                    cur_next = cur_reg + tccw_pkg::ADDR_W'(1);
                    col_next = col_reg + tccw_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg <= cur_next;
            col_reg <= col_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg      <= s_tuser[0];
            ch_reg       <= s_tdata[7:0];
            attr_reg     <= s_tdata[15:8] | tccw_pkg::ATTR_FORCE;
            idx_ok_reg   <= (idx_wide < tccw_pkg::WIDE_W'(tccw_pkg::CELL_COUNT));
            idx_addr_reg <= idx_wide[tccw_pkg::ADDR_W-1:0];
        end
        if (cmd.exec)
        begin
            scrolled_reg <= scroll_needed;
        end
        if (cmd.emit)
        begin
            out_cursor_reg   <= cur_wide[10:0];
            out_scrolled_reg <= scrolled_reg;
            if ((cmd_reg == tccw_pkg::CMD_READ) && idx_ok_reg)
            begin
                out_cell_reg <= rdata_reg;
            end
            else
            begin
                out_cell_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_scrolled_reg, out_cell_reg, out_cursor_reg};

endmodule

`default_nettype wire

// ----- rtl/tccw_checker.sv -----
// Port-level checker of the text console writer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tccw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

    // The block works on one item at a time, so it is busy right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("second beat accepted while an item is in progress");

    // The cursor reported never leaves the screen and the padding bits stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:0] < 11'(tccw_pkg::CELL_COUNT)) && (m_tdata[31:28] == 4'b0000))
    else $error("cursor out of range or padding set");

    // Every scroll leaves the cursor at the start of the last row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[27] |->
            m_tdata[10:0] == 11'(tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS))
    else $error("scroll left the cursor off the last row start");

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
